/* design/blrc_pkg.sv */
// ----------------------------------------------------------------------------
// blrc_pkg
// Shared types and constants for the binary link record checker: parse
// phases, result kinds, error codes and the packed result item.
// ----------------------------------------------------------------------------
`default_nettype none

package blrc_pkg;

   typedef enum logic [3:0] {
      PH_HEADER,
      PH_WLEN,
      PH_WORD,
      PH_TOT_LO,
      PH_TOT_HI,
      PH_NPAIRS,
      PH_PAIR,
      PH_FOOT_LO,
      PH_FOOT_HI,
      PH_IDLE
   } phase_type;

   localparam logic [1:0] KIND_RECORD  = 2'd0;
   localparam logic [1:0] KIND_SUMMARY = 2'd1;
   localparam logic [1:0] KIND_FATAL   = 2'd2;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_BAD_MAGIC   = 3'd1;
   localparam logic [2:0] ERR_BAD_VERSION = 3'd2;
   localparam logic [2:0] ERR_WORD_LONG   = 3'd3;
   localparam logic [2:0] ERR_TRUNCATED   = 3'd4;
   localparam logic [2:0] ERR_MANY_PAIRS  = 3'd5;
   localparam logic [2:0] ERR_NO_CHECKSUM = 3'd6;

   localparam logic [7:0] MAGIC_0      = 8'h4E;
   localparam logic [7:0] MAGIC_1      = 8'h49;
   localparam logic [7:0] MAGIC_2      = 8'h41;
   localparam logic [7:0] MAGIC_3      = 8'h4C;
   localparam logic [7:0] FILE_VERSION = 8'd4;

   localparam int TDATA_W = 112;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [15:0] entry_index;
      logic        record_ok;
      logic [15:0] record_total;
      logic [7:0]  record_pairs;
      logic        entry_warning;
      logic [2:0]  error_code;
      logic        checksum_ok;
      logic [16:0] error_count;
      logic [22:0] pair_total;
      logic [15:0] pair_least;
      logic [7:0]  pair_most;
   } result_type;

endpackage

`default_nettype wire

/* design/blrc_skid.sv */
// ----------------------------------------------------------------------------
// blrc_skid
// Two-entry output buffer for result requests: an output register plus a
// skid register, so the input side waits only while the skid register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module blrc_skid
   import blrc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output      logic       in_ready,
   input  wire result_type in_data,
   output      logic       out_valid,
   input  wire logic       out_ready,
   output      result_type out_data
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign pop       = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

/* design/blrc_parser.sv */
// ----------------------------------------------------------------------------
// blrc_parser
// Byte-wide parse of the save file: header check, record fields, pair
// sums, payload checksum and the running summary; one byte per cycle while accept is high.
// ----------------------------------------------------------------------------
`default_nettype none

module blrc_parser
   import blrc_pkg::*;
#(
   parameter int MAX_PAIRS = 100,
   parameter int MAX_WORD  = 31
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   input  wire logic       file_start,
   input  wire logic       file_end,
   output      logic       result_valid,
   output      result_type result
);

   localparam int SUM_W = $clog2(MAX_PAIRS * 65535 + 1);
   localparam int CMP_W = SUM_W + 16;
   localparam logic [7:0] MAX_PAIRS_B = 8'(MAX_PAIRS);
   localparam logic [7:0] MAX_WORD_B  = 8'(MAX_WORD);

   localparam logic [7:0] HDR_VER_POS    = 8'd4;
   localparam logic [7:0] HDR_CNT_LO_POS = 8'd5;
   localparam logic [7:0] HDR_LAST_POS   = 8'd6;

   localparam logic [1:0] PAIR_ID_LO  = 2'd0;
   localparam logic [1:0] PAIR_ID_HI  = 2'd1;
   localparam logic [1:0] PAIR_CNT_LO = 2'd2;
   localparam logic [1:0] PAIR_CNT_HI = 2'd3;

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   phase_type          phase_ff, phase_in, c_phase;
   logic [7:0]         pos_ff, pos_in, c_pos;
   logic [15:0]        wc_ff, wc_in, c_wc;
   logic [15:0]        entry_ff, entry_in, c_entry;
   logic [7:0]         wlen_ff, wlen_in, c_wlen;
   logic [15:0]        csum_ff, csum_in, c_csum;
   logic [15:0]        total_ff, total_in, c_total;
   logic [7:0]         npairs_ff, npairs_in, c_npairs;
   logic [7:0]         remain_ff, remain_in, c_remain;
   logic [SUM_W-1:0]   sum_ff, sum_in, c_sum;
   logic [7:0]         low_ff, low_in, c_low;
   logic               ok_ff, ok_in, c_ok;
   logic               warn_ff, warn_in, c_warn;
   logic               magic_bad_ff, magic_bad_in, c_magic_bad;
   logic               ver_bad_ff, ver_bad_in, c_ver_bad;
   logic [16:0]        bad_ff, bad_in, c_bad;
   logic [22:0]        acc_ff, acc_in, c_acc;
   logic [15:0]        least_ff, least_in, c_least;
   logic [7:0]         most_ff, most_in, c_most;

   logic               has_result;
   logic               do_finish;
   logic               rec_ok;
   logic [7:0]         b;

   assign b            = data_byte;
   assign result_valid = accept && has_result;

   always_comb begin
      // a start marker restarts the parse before the byte is taken
      c_phase     = file_start ? PH_HEADER : phase_ff;
      c_pos       = file_start ? '0 : pos_ff;
      c_wc        = file_start ? '0 : wc_ff;
      c_entry     = file_start ? '0 : entry_ff;
      c_wlen      = file_start ? '0 : wlen_ff;
      c_csum      = file_start ? '0 : csum_ff;
      c_total     = file_start ? '0 : total_ff;
      c_npairs    = file_start ? '0 : npairs_ff;
      c_remain    = file_start ? '0 : remain_ff;
      c_sum       = file_start ? '0 : sum_ff;
      c_low       = file_start ? '0 : low_ff;
      c_ok        = file_start ? 1'b1 : ok_ff;
      c_warn      = file_start ? 1'b0 : warn_ff;
      c_magic_bad = file_start ? 1'b0 : magic_bad_ff;
      c_ver_bad   = file_start ? 1'b0 : ver_bad_ff;
      c_bad       = file_start ? '0 : bad_ff;
      c_acc       = file_start ? '0 : acc_ff;
      c_least     = file_start ? 16'hFFFF : least_ff;
      c_most      = file_start ? '0 : most_ff;

      phase_in     = c_phase;
      pos_in       = c_pos;
      wc_in        = c_wc;
      entry_in     = c_entry;
      wlen_in      = c_wlen;
      csum_in      = c_csum;
      total_in     = c_total;
      npairs_in    = c_npairs;
      remain_in    = c_remain;
      sum_in       = c_sum;
      low_in       = c_low;
      ok_in        = c_ok;
      warn_in      = c_warn;
      magic_bad_in = c_magic_bad;
      ver_bad_in   = c_ver_bad;
      bad_in       = c_bad;
      acc_in       = c_acc;
      least_in     = c_least;
      most_in      = c_most;

      has_result = 1'b0;
      do_finish  = 1'b0;
      rec_ok     = 1'b0;
      result     = '0;

      if (file_end) begin
         if (c_phase != PH_IDLE) begin
            has_result         = 1'b1;
            result.result_kind = KIND_FATAL;
            phase_in           = PH_IDLE;
            if (c_phase == PH_HEADER) begin
               result.error_code = ERR_TRUNCATED;
            end else if (c_phase == PH_FOOT_LO || c_phase == PH_FOOT_HI) begin
               result.entry_index = c_entry;
               result.error_code  = ERR_NO_CHECKSUM;
            end else begin
               result.entry_index = c_entry;
               result.error_code  = ERR_TRUNCATED;
            end
         end
      end else begin
         if (c_phase != PH_HEADER && c_phase != PH_IDLE &&
             c_phase != PH_FOOT_LO && c_phase != PH_FOOT_HI) begin
            csum_in = c_csum + 16'(b);
         end

         unique case (c_phase)
            PH_HEADER: begin
               if ((c_pos == 8'd0 && b != MAGIC_0) || (c_pos == 8'd1 && b != MAGIC_1) ||
                   (c_pos == 8'd2 && b != MAGIC_2) || (c_pos == 8'd3 && b != MAGIC_3)) begin
                  magic_bad_in = 1'b1;
               end
               if (c_pos == HDR_VER_POS && b != FILE_VERSION) begin
                  ver_bad_in = 1'b1;
               end
               if (c_pos == HDR_CNT_LO_POS) begin
                  low_in = b;
               end
               if (c_pos < HDR_LAST_POS) begin
                  pos_in = c_pos + 8'd1;
               end else begin
                  wc_in = {b, c_low};
                  if (c_magic_bad) begin
                     has_result         = 1'b1;
                     result.result_kind = KIND_FATAL;
                     result.error_code  = ERR_BAD_MAGIC;
                     phase_in           = PH_IDLE;
                  end else if (c_ver_bad) begin
                     has_result         = 1'b1;
                     result.result_kind = KIND_FATAL;
                     result.error_code  = ERR_BAD_VERSION;
                     phase_in           = PH_IDLE;
                  end else begin
                     ok_in        = 1'b1;
                     warn_in      = 1'b0;
                     magic_bad_in = 1'b0;
                     ver_bad_in   = 1'b0;
                     pos_in       = '0;
                     phase_in     = PH_WLEN;
                  end
               end
            end
            PH_WLEN: begin
               ok_in     = 1'b1;
               warn_in   = 1'b0;
               sum_in    = '0;
               total_in  = '0;
               npairs_in = '0;
               if (b > MAX_WORD_B) begin
                  has_result         = 1'b1;
                  result.result_kind = KIND_FATAL;
                  result.entry_index = c_entry;
                  result.error_code  = ERR_WORD_LONG;
                  phase_in           = PH_IDLE;
               end else begin
                  wlen_in  = b;
                  warn_in  = (c_entry == 16'd0) && (b != 8'd0);
                  pos_in   = '0;
                  phase_in = (b == 8'd0) ? PH_TOT_LO : PH_WORD;
               end
            end
            PH_WORD: begin
               if (c_entry != 16'd0 && !is_alnum(b)) begin
                  warn_in = 1'b1;
               end
               pos_in = c_pos + 8'd1;
               if ({1'b0, c_pos} + 9'd1 >= {1'b0, c_wlen}) begin
                  phase_in = PH_TOT_LO;
               end
            end
            PH_TOT_LO: begin
               low_in   = b;
               phase_in = PH_TOT_HI;
            end
            PH_TOT_HI: begin
               total_in = {b, c_low};
               phase_in = PH_NPAIRS;
            end
            PH_NPAIRS: begin
               npairs_in = b;
               if (b > MAX_PAIRS_B) begin
                  has_result         = 1'b1;
                  result.result_kind = KIND_FATAL;
                  result.entry_index = c_entry;
                  result.error_code  = ERR_MANY_PAIRS;
                  phase_in           = PH_IDLE;
               end else if (b == 8'd0) begin
                  do_finish = 1'b1;
               end else begin
                  remain_in = b;
                  pos_in    = '0;
                  phase_in  = PH_PAIR;
               end
            end
            PH_PAIR: begin
               case (c_pos[1:0])
                  PAIR_ID_LO, PAIR_CNT_LO: begin
                     low_in = b;
                     pos_in = c_pos + 8'd1;
                  end
                  PAIR_ID_HI: begin
                     if (c_low == 8'd0 && b == 8'd0) begin
                        ok_in = 1'b0;
                     end
                     pos_in = 8'(PAIR_CNT_LO);
                  end
                  PAIR_CNT_HI: begin
                     sum_in    = c_sum + SUM_W'({b, c_low});
                     pos_in    = '0;
                     remain_in = c_remain - 8'd1;
                     if (c_remain == 8'd1) begin
                        do_finish = 1'b1;
                     end
                  end
                  default: begin
                     pos_in = '0;
                  end
               endcase
            end
            PH_FOOT_LO: begin
               low_in   = b;
               phase_in = PH_FOOT_HI;
            end
            PH_FOOT_HI: begin
               has_result         = 1'b1;
               result.result_kind = KIND_SUMMARY;
               result.entry_index = c_wc;
               result.checksum_ok = ({b, c_low} == c_csum);
               result.error_count = c_bad;
               result.pair_total  = c_acc;
               result.pair_least  = c_least;
               result.pair_most   = c_most;
               phase_in           = PH_IDLE;
            end
            PH_IDLE: begin
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         if (do_finish) begin
            rec_ok               = ok_in && (CMP_W'(sum_in) == CMP_W'(total_in));
            has_result           = 1'b1;
            result.result_kind   = KIND_RECORD;
            result.entry_index   = c_entry;
            result.record_ok     = rec_ok;
            result.record_total  = total_in;
            result.record_pairs  = npairs_in;
            result.entry_warning = warn_in;
            if (rec_ok) begin
               acc_in = c_acc + 23'(npairs_in);
               if (16'(npairs_in) < c_least) begin
                  least_in = 16'(npairs_in);
               end
               if (npairs_in > c_most) begin
                  most_in = npairs_in;
               end
            end else begin
               bad_in = c_bad + 17'd1;
            end
            if (c_entry == c_wc) begin
               phase_in = PH_FOOT_LO;
            end else begin
               entry_in = c_entry + 16'd1;
               phase_in = PH_WLEN;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         wc_ff        <= '0;
         entry_ff     <= '0;
         wlen_ff      <= '0;
         csum_ff      <= '0;
         total_ff     <= '0;
         npairs_ff    <= '0;
         remain_ff    <= '0;
         sum_ff       <= '0;
         low_ff       <= '0;
         ok_ff        <= 1'b1;
         warn_ff      <= 1'b0;
         magic_bad_ff <= 1'b0;
         ver_bad_ff   <= 1'b0;
         bad_ff       <= '0;
         acc_ff       <= '0;
         least_ff     <= 16'hFFFF;
         most_ff      <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         wc_ff        <= wc_in;
         entry_ff     <= entry_in;
         wlen_ff      <= wlen_in;
         csum_ff      <= csum_in;
         total_ff     <= total_in;
         npairs_ff    <= npairs_in;
         remain_ff    <= remain_in;
         sum_ff       <= sum_in;
         low_ff       <= low_in;
         ok_ff        <= ok_in;
         warn_ff      <= warn_in;
         magic_bad_ff <= magic_bad_in;
         ver_bad_ff   <= ver_bad_in;
         bad_ff       <= bad_in;
         acc_ff       <= acc_in;
         least_ff     <= least_in;
         most_ff      <= most_in;
      end
   end

endmodule

`default_nettype wire

/* design/binary_link_record_checker_top.sv */
// ----------------------------------------------------------------------------
// binary_link_record_checker_top
// Checks a binary link save file streamed one byte per request and gives a
// result per record, an end summary or a fatal error.
// ----------------------------------------------------------------------------
// a result reaches rsp from the output register and waits in the skid register while an older one is held
// throughput: one request per cycle while req_tready is high, set by the combinational parse update
// a two-entry output buffer keeps req_tready high while one result waits
// reset: synchronous, clears the parse to the start of a header
// ----------------------------------------------------------------------------
`default_nettype none

module binary_link_record_checker_top
   import blrc_pkg::*;
#(
   parameter int MAX_PAIRS = 100,
   parameter int MAX_WORD  = 31
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output      logic               req_tready,
   input  wire logic [7:0]         req_tdata,  // data_byte
   input  wire logic [1:0]         req_tuser,  // file_start, file_end
   output      logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   output      logic [TDATA_W-1:0] rsp_tdata,  // entry_index, record_ok, record_total,
                                               // record_pairs, entry_warning, error_code,
                                               // checksum_ok, error_count, pair_total,
                                               // pair_least, pair_most, zero fill
   output      logic [1:0]         rsp_tuser   // result_kind
);

   logic       accept;
   logic       push;
   result_type new_result;
   result_type out_result;

   assign accept = req_tvalid && req_tready;

   blrc_parser #(
      .MAX_PAIRS (MAX_PAIRS),
      .MAX_WORD  (MAX_WORD)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_tdata),
      .file_start   (req_tuser[0]),
      .file_end     (req_tuser[1]),
      .result_valid (push),
      .result       (new_result)
   );

   blrc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push),
      .in_ready  (req_tready),
      .in_data   (new_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_result)
   );

   assign rsp_tuser = out_result.result_kind;
   assign rsp_tdata = {2'b00,
                       out_result.pair_most,
                       out_result.pair_least,
                       out_result.pair_total,
                       out_result.error_count,
                       out_result.checksum_ok,
                       out_result.error_code,
                       out_result.entry_warning,
                       out_result.record_pairs,
                       out_result.record_total,
                       out_result.record_ok,
                       out_result.entry_index};

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

   a_empty_file_fatal: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser[0] && req_tuser[1]) |=> rsp_tvalid)
      else $error("empty file gave no result");

   a_fatal_has_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_FATAL) |-> (rsp_tdata[44:42] != ERR_NONE))
      else $error("fatal result without error code");

   a_record_no_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_RECORD) |-> (rsp_tdata[44:42] == ERR_NONE))
      else $error("record result carries error code");

endmodule

`default_nettype wire

/* tb/blrc_result_checker.sv */
// ----------------------------------------------------------------------------
// blrc_result_checker
// Watches the request and result streams of the binary link record checker.
// It keeps its own parse of every accepted request and compares each result
// that leaves the block with the oldest predicted one.
// ----------------------------------------------------------------------------

module blrc_result_checker
   import blrc_pkg::*;
#(
   parameter int MAX_PAIRS = 100,
   parameter int MAX_WORD  = 31
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   input  wire logic               req_tready,
   input  wire logic [7:0]         req_tdata,  // data_byte
   input  wire logic [1:0]         req_tuser,  // file_start, file_end
   input  wire logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   input  wire logic [TDATA_W-1:0] rsp_tdata,  // entry_index .. pair_most, zero fill
   input  wire logic [1:0]         rsp_tuser,  // result_kind
   output int                      failures,
   output int                      results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   result_type predicted_results[$];

   phase_type   parse_phase;
   logic [7:0]  byte_pos;
   logic [15:0] word_cnt;
   logic [15:0] entry_idx;
   logic [7:0]  word_len;
   logic [15:0] payload_sum;
   logic [15:0] held_total;
   logic [7:0]  held_pairs;
   logic [7:0]  pairs_left;
   logic [31:0] id_count_sum;
   logic [7:0]  held_low;
   logic        rec_good;
   logic        rec_warn;
   logic        magic_bad;
   logic        version_bad;
   logic [16:0] bad_records;
   logic [22:0] good_pairs_total;
   logic [15:0] fewest_pairs;
   logic [7:0]  most_pairs_seen;

   task automatic restart_parse();
      parse_phase      = PH_HEADER;
      byte_pos         = '0;
      word_cnt         = '0;
      entry_idx        = '0;
      word_len         = '0;
      payload_sum      = '0;
      held_total       = '0;
      held_pairs       = '0;
      pairs_left       = '0;
      id_count_sum     = '0;
      held_low         = '0;
      rec_good         = 1'b1;
      rec_warn         = 1'b0;
      magic_bad        = 1'b0;
      version_bad      = 1'b0;
      bad_records      = '0;
      good_pairs_total = '0;
      fewest_pairs     = 16'hFFFF;
      most_pairs_seen  = '0;
   endtask

   function automatic logic is_word_char(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic string show(input result_type r);
      return $sformatf({"kind=%0d idx=%0d ok=%0d total=%0d n=%0d warn=%0d err=%0d ",
                        "csum=%0d bad=%0d pairs=%0d min=%0d max=%0d"},
                       r.result_kind, r.entry_index, r.record_ok, r.record_total,
                       r.record_pairs, r.entry_warning, r.error_code, r.checksum_ok,
                       r.error_count, r.pair_total, r.pair_least, r.pair_most);
   endfunction

   task automatic raise_fatal(input logic [15:0] idx, input logic [2:0] code);
      result_type r;
      r             = '0;
      r.result_kind = KIND_FATAL;
      r.entry_index = idx;
      r.error_code  = code;
      predicted_results.push_back(r);
      parse_phase = PH_IDLE;
   endtask

   task automatic close_record();
      result_type r;
      logic       ok;
      ok              = rec_good && (id_count_sum == {16'b0, held_total});
      r               = '0;
      r.result_kind   = KIND_RECORD;
      r.entry_index   = entry_idx;
      r.record_ok     = ok;
      r.record_total  = held_total;
      r.record_pairs  = held_pairs;
      r.entry_warning = rec_warn;
      predicted_results.push_back(r);
      if (ok) begin
         good_pairs_total = good_pairs_total + 23'(held_pairs);
         if ({8'b0, held_pairs} < fewest_pairs) fewest_pairs = {8'b0, held_pairs};
         if (held_pairs > most_pairs_seen) most_pairs_seen = held_pairs;
      end else begin
         bad_records = bad_records + 17'd1;
      end
      if (entry_idx == word_cnt) begin
         parse_phase = PH_FOOT_LO;
      end else begin
         entry_idx   = entry_idx + 16'd1;
         parse_phase = PH_WLEN;
      end
   endtask

   task automatic predict_parse(input logic [7:0] b, input logic s, input logic e);
      result_type  r;
      logic [15:0] saved;
      if (s) restart_parse();
      if (e) begin
         case (parse_phase)
            PH_IDLE: ;
            PH_HEADER: raise_fatal('0, ERR_TRUNCATED);
            PH_FOOT_LO, PH_FOOT_HI: raise_fatal(entry_idx, ERR_NO_CHECKSUM);
            default: raise_fatal(entry_idx, ERR_TRUNCATED);
         endcase
         return;
      end
      if (parse_phase != PH_HEADER && parse_phase != PH_IDLE &&
          parse_phase != PH_FOOT_LO && parse_phase != PH_FOOT_HI)
         payload_sum = payload_sum + 16'(b);
      case (parse_phase)
         PH_HEADER: begin
            case (byte_pos)
               0: if (b != MAGIC_0) magic_bad = 1'b1;
               1: if (b != MAGIC_1) magic_bad = 1'b1;
               2: if (b != MAGIC_2) magic_bad = 1'b1;
               3: if (b != MAGIC_3) magic_bad = 1'b1;
               4: if (b != FILE_VERSION) version_bad = 1'b1;
               5: held_low = b;
               default: ;
            endcase
            if (byte_pos < 6) begin
               byte_pos = byte_pos + 8'd1;
            end else begin
               word_cnt = {b, held_low};
               if (magic_bad) begin
                  raise_fatal('0, ERR_BAD_MAGIC);
               end else if (version_bad) begin
                  raise_fatal('0, ERR_BAD_VERSION);
               end else begin
                  rec_good    = 1'b1;
                  rec_warn    = 1'b0;
                  byte_pos    = '0;
                  parse_phase = PH_WLEN;
               end
            end
         end
         PH_WLEN: begin
            rec_good     = 1'b1;
            rec_warn     = 1'b0;
            id_count_sum = '0;
            held_total   = '0;
            held_pairs   = '0;
            if (b > MAX_WORD) begin
               raise_fatal(entry_idx, ERR_WORD_LONG);
            end else begin
               word_len = b;
               if (entry_idx == 0 && b != 0) rec_warn = 1'b1;
               byte_pos    = '0;
               parse_phase = (b == 0) ? PH_TOT_LO : PH_WORD;
            end
         end
         PH_WORD: begin
            if (entry_idx != 0 && !is_word_char(b)) rec_warn = 1'b1;
            byte_pos = byte_pos + 8'd1;
            if (byte_pos >= word_len) parse_phase = PH_TOT_LO;
         end
         PH_TOT_LO: begin
            held_low    = b;
            parse_phase = PH_TOT_HI;
         end
         PH_TOT_HI: begin
            held_total  = {b, held_low};
            parse_phase = PH_NPAIRS;
         end
         PH_NPAIRS: begin
            held_pairs = b;
            if (b > MAX_PAIRS) begin
               raise_fatal(entry_idx, ERR_MANY_PAIRS);
            end else if (b == 0) begin
               close_record();
            end else begin
               pairs_left  = b;
               byte_pos    = '0;
               parse_phase = PH_PAIR;
            end
         end
         PH_PAIR: begin
            case (byte_pos)
               0, 2: begin
                  held_low = b;
                  byte_pos = byte_pos + 8'd1;
               end
               1: begin
                  if (held_low == 0 && b == 0) rec_good = 1'b0;
                  byte_pos = 8'd2;
               end
               default: begin
                  id_count_sum = id_count_sum + {16'b0, b, held_low};
                  byte_pos     = '0;
                  pairs_left   = pairs_left - 8'd1;
                  if (pairs_left == 0) close_record();
               end
            endcase
         end
         PH_FOOT_LO: begin
            held_low    = b;
            parse_phase = PH_FOOT_HI;
         end
         PH_FOOT_HI: begin
            saved         = {b, held_low};
            r             = '0;
            r.result_kind = KIND_SUMMARY;
            r.entry_index = word_cnt;
            r.checksum_ok = (saved == payload_sum);
            r.error_count = bad_records;
            r.pair_total  = good_pairs_total;
            r.pair_least  = fewest_pairs;
            r.pair_most   = most_pairs_seen;
            predicted_results.push_back(r);
            parse_phase = PH_IDLE;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (reset) begin
         restart_parse();
         predicted_results.delete();
      end else begin
         if (req_tvalid && req_tready) predict_parse(req_tdata, req_tuser[0], req_tuser[1]);
         if (rsp_tvalid && rsp_tready) begin
            seen.result_kind   = rsp_tuser;
            seen.entry_index   = rsp_tdata[15:0];
            seen.record_ok     = rsp_tdata[16];
            seen.record_total  = rsp_tdata[32:17];
            seen.record_pairs  = rsp_tdata[40:33];
            seen.entry_warning = rsp_tdata[41];
            seen.error_code    = rsp_tdata[44:42];
            seen.checksum_ok   = rsp_tdata[45];
            seen.error_count   = rsp_tdata[62:46];
            seen.pair_total    = rsp_tdata[85:63];
            seen.pair_least    = rsp_tdata[101:86];
            seen.pair_most     = rsp_tdata[109:102];
            if (predicted_results.size() == 0) begin
               if (failures < 10) $display("unexpected result: %s", show(seen));
               failures <= failures + 1;
            end else begin
               want = predicted_results.pop_front();
               if (seen !== want) begin
                  if (failures < 10)
                     $display("result mismatch\n  expected %s\n  actual   %s",
                              show(want), show(seen));
                  failures <= failures + 1;
               end
            end
         end
      end
      results_owed <= predicted_results.size();
   end

endmodule

/* tb/tb_binary_link_record_checker_top.sv */
// ----------------------------------------------------------------------------
// tb_binary_link_record_checker_top
// Streams save files into the binary link record checker: directed files for
// header faults, long words, too many pairs, truncation, missing footers and
// bad records, then random files, mostly well formed, some cut short or
// damaged. The sender bursts and idles, the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------

module tb_binary_link_record_checker_top;
   timeunit 1ns;
   timeprecision 1ps;

   import blrc_pkg::*;

   localparam int MAX_PAIRS    = 100;
   localparam int MAX_WORD     = 31;
   localparam int ITEM_TARGET  = 1950;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [31:0] GOOD_MAGIC = {MAGIC_3, MAGIC_2, MAGIC_1, MAGIC_0};

   typedef enum {PAIR_GOOD, PAIR_ZERO_ID, PAIR_WIDE, PAIR_BAD_TOTAL, PAIR_FULL} pair_style_type;
   typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = '0;  // data_byte
   logic [1:0]         req_tuser  = '0;  // file_start, file_end
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;       // entry_index .. pair_most, zero fill
   logic [1:0]         rsp_tuser;       // result_kind

   int          failures;
   int          results_owed;
   int          cycle_count;
   int          items_sent;
   int          burst_left;
   rx_mode_type rx_mode;
   int          rx_left;
   logic [7:0]  rx_mask;
   logic [7:0]  file_q[$];
   logic [15:0] file_sum;

   binary_link_record_checker_top #(
      .MAX_PAIRS (MAX_PAIRS),
      .MAX_WORD  (MAX_WORD)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   blrc_result_checker #(
      .MAX_PAIRS (MAX_PAIRS),
      .MAX_WORD  (MAX_WORD)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .failures     (failures),
      .results_owed (results_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver stalls, mode changes when its random hold count runs out
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode    <= rx_mode_type'($urandom_range(0, 3));
         rx_mask    <= 8'($urandom_range(0, 255)) | 8'h01;
         rx_left    <= $urandom_range(20, 300);
         rsp_tready <= 1'b1;
      end else begin
         rx_left <= rx_left - 1;
         case (rx_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: begin
               rsp_tready <= rx_mask[0];
               rx_mask    <= {rx_mask[0], rx_mask[7:1]};
            end
            default:   rsp_tready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   task automatic send_item(input logic [7:0] b, input logic s, input logic e);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {e, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   function automatic logic [7:0] word_byte(input bit plain);
      int k;
      logic [7:0] edges[12];
      edges = '{8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40, 8'h41, 8'h5A, 8'h5B,
                8'h60, 8'h61, 8'h7A, 8'h7B};
      k = $urandom_range(0, 3);
      if (!plain && k == 0) return 8'($urandom_range(0, 255));
      if (!plain && k == 1) return edges[$urandom_range(0, 11)];
      k = $urandom_range(0, 61);
      if (k < 10) return 8'h30 + 8'(k);
      if (k < 36) return 8'h41 + 8'(k - 10);
      return 8'h61 + 8'(k - 36);
   endfunction

   function automatic logic [15:0] nonzero_id();
      case ($urandom_range(0, 3))
         0: return {8'($urandom_range(1, 255)), 8'h00};
         1: return {8'h00, 8'($urandom_range(1, 255))};
         default: return 16'($urandom_range(1, 65535));
      endcase
   endfunction

   task automatic push_payload(input logic [7:0] b);
      file_q.push_back(b);
      file_sum = file_sum + 16'(b);
   endtask

   task automatic put_header(input logic [31:0] magic, input logic [7:0] version,
                             input logic [15:0] count);
      file_sum = '0;
      file_q.push_back(magic[7:0]);
      file_q.push_back(magic[15:8]);
      file_q.push_back(magic[23:16]);
      file_q.push_back(magic[31:24]);
      file_q.push_back(version);
      file_q.push_back(count[7:0]);
      file_q.push_back(count[15:8]);
   endtask

   task automatic put_record(input int wlen, input bit plain, input int npairs,
                             input pair_style_type style);
      int          i;
      int          zero_slot;
      logic [15:0] id;
      logic [15:0] cnt;
      logic [31:0] sum;
      logic [15:0] total;
      logic [7:0]  pair_bytes[$];
      push_payload(8'(wlen));
      if (wlen > MAX_WORD) return;
      for (i = 0; i < wlen; i++) push_payload(word_byte(plain));
      sum       = '0;
      zero_slot = (style == PAIR_ZERO_ID && npairs > 0) ? $urandom_range(0, npairs - 1) : -1;
      if (npairs <= MAX_PAIRS) begin
         for (i = 0; i < npairs; i++) begin
            id = (i == zero_slot) ? 16'h0000 : nonzero_id();
            case (style)
               PAIR_WIDE: cnt = 16'($urandom_range(0, 65535));
               PAIR_FULL: cnt = 16'(65535 / npairs);
               default:   cnt = 16'($urandom_range(0, 65535 / npairs));
            endcase
            sum = sum + 32'(cnt);
            pair_bytes.push_back(id[7:0]);
            pair_bytes.push_back(id[15:8]);
            pair_bytes.push_back(cnt[7:0]);
            pair_bytes.push_back(cnt[15:8]);
         end
      end
      total = (style == PAIR_BAD_TOTAL) ? 16'($urandom_range(0, 65535)) : sum[15:0];
      push_payload(total[7:0]);
      push_payload(total[15:8]);
      push_payload(8'(npairs));
      foreach (pair_bytes[j]) push_payload(pair_bytes[j]);
   endtask

   task automatic put_footer(input bit corrupt);
      logic [15:0] f;
      f = file_sum ^ (corrupt ? 16'($urandom_range(1, 65535)) : 16'h0000);
      file_q.push_back(f[7:0]);
      file_q.push_back(f[15:8]);
   endtask

   // keep < 0 sends the whole file
   task automatic send_file(input bit with_start, input int keep, input bit with_end);
      int n;
      int i;
      n = (keep < 0 || keep > file_q.size()) ? file_q.size() : keep;
      for (i = 0; i < n; i++) send_item(file_q[i], with_start && i == 0, 1'b0);
      if (with_end) send_item(8'($urandom_range(0, 255)), with_start && n == 0, 1'b1);
      file_q.delete();
   endtask

   task automatic random_file();
      int             cnt;
      int             i;
      int             k;
      int             wlen;
      int             npairs;
      int             keep;
      logic [31:0]    magic;
      logic [7:0]     version;
      logic [15:0]    count_field;
      pair_style_type style;
      magic   = GOOD_MAGIC;
      version = FILE_VERSION;
      k       = $urandom_range(0, 99);
      if (k < 4) begin
         k = $urandom_range(0, 3);
         magic[k*8 +: 8] = magic[k*8 +: 8] ^ 8'($urandom_range(1, 255));
      end else if (k < 7) begin
         version = 8'($urandom_range(0, 255));
      end
      cnt         = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      count_field = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535)) : 16'(cnt);
      put_header(magic, version, count_field);
      for (i = 0; i <= cnt; i++) begin
         if (i == 0)
            wlen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_WORD) : 0;
         else
            wlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_WORD)
                                               : $urandom_range(0, 6);
         if ($urandom_range(0, 49) == 0) wlen = $urandom_range(MAX_WORD + 1, 255);
         k = $urandom_range(0, 99);
         if (k < 86)      npairs = $urandom_range(0, 4);
         else if (k < 97) npairs = $urandom_range(5, MAX_PAIRS);
         else             npairs = $urandom_range(MAX_PAIRS + 1, 255);
         style = ($urandom_range(0, 1) == 0) ? PAIR_GOOD
                                             : pair_style_type'($urandom_range(0, 4));
         put_record(wlen, $urandom_range(0, 3) != 0, npairs, style);
      end
      put_footer($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 4)) file_q.push_back(8'($urandom_range(0, 255)));
      keep = ($urandom_range(0, 6) == 0) ? $urandom_range(0, file_q.size() - 1) : -1;
      send_file($urandom_range(0, 29) != 0, keep, $urandom_range(0, 3) != 0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // no file_start after reset, then an end after the summary
      put_header(GOOD_MAGIC, FILE_VERSION, 16'd1);
      put_record(0, 1'b1, 0, PAIR_GOOD);
      put_record(5, 1'b1, 2, PAIR_GOOD);
      put_footer(1'b0);
      send_file(1'b0, -1, 1'b1);

      // empty file: start and end together
      send_file(1'b1, 0, 1'b1);

      // bad magic and bad version, magic wins; trailing bytes ignored
      put_header({MAGIC_3, MAGIC_2, MAGIC_1, 8'h00}, 8'd3, 16'd0);
      file_q.push_back(8'hFF);
      file_q.push_back(8'h00);
      send_file(1'b1, -1, 1'b1);

      // bad version only
      put_header(GOOD_MAGIC, 8'hFF, 16'hFFFF);
      send_file(1'b1, -1, 1'b0);

      // short header
      put_header(GOOD_MAGIC, FILE_VERSION, 16'd0);
      send_file(1'b1, 3, 1'b1);

      // word too long at a later record and at the first
      put_header(GOOD_MAGIC, FILE_VERSION, 16'd2);
      put_record(0, 1'b1, 1, PAIR_GOOD);
      put_record(MAX_WORD + 1, 1'b1, 0, PAIR_GOOD);
      send_file(1'b1, -1, 1'b1);
      put_header(GOOD_MAGIC, FILE_VERSION, 16'd0);
      put_record(255, 1'b1, 0, PAIR_GOOD);
      send_file(1'b1, -1, 1'b0);

      // too many pairs
      put_header(GOOD_MAGIC, FILE_VERSION, 16'd0);
      put_record(0, 1'b1, MAX_PAIRS + 1, PAIR_GOOD);
      send_file(1'b1, -1, 1'b0);
      put_header(GOOD_MAGIC, FILE_VERSION, 16'd1);
      put_record(0, 1'b1, 0, PAIR_GOOD);
      put_record(2, 1'b1, 255, PAIR_GOOD);
      send_file(1'b1, -1, 1'b1);

      // full pair count, longest odd word, warning on entry zero
      put_header(GOOD_MAGIC, FILE_VERSION, 16'd1);
      put_record(3, 1'b1, 0, PAIR_GOOD);
      put_record(MAX_WORD, 1'b0, MAX_PAIRS, PAIR_GOOD);
      put_footer(1'b0);
      send_file(1'b1, -1, 1'b1);

      // zero id, overflowing sum, wrong total, largest total, bad checksum
      put_header(GOOD_MAGIC, FILE_VERSION, 16'd4);
      put_record(0, 1'b1, 3, PAIR_ZERO_ID);
      put_record(4, 1'b1, 4, PAIR_WIDE);
      put_record(4, 1'b0, 2, PAIR_BAD_TOTAL);
      put_record(1, 1'b1, 1, PAIR_FULL);
      put_record(0, 1'b1, 0, PAIR_GOOD);
      put_footer(1'b1);
      send_file(1'b1, -1, 1'b1);

      // every record bad
      put_header(GOOD_MAGIC, FILE_VERSION, 16'd1);
      put_record(0, 1'b1, 2, PAIR_ZERO_ID);
      put_record(2, 1'b1, 1, PAIR_ZERO_ID);
      put_footer(1'b0);
      send_file(1'b1, -1, 1'b0);

      // truncated inside the pairs
      put_header(GOOD_MAGIC, FILE_VERSION, 16'd1);
      put_record(0, 1'b1, 1, PAIR_GOOD);
      put_record(3, 1'b1, 3, PAIR_GOOD);
      put_footer(1'b0);
      send_file(1'b1, file_q.size() - 5, 1'b1);

      // footer missing, whole and half
      put_header(GOOD_MAGIC, FILE_VERSION, 16'd0);
      put_record(0, 1'b1, 1, PAIR_GOOD);
      put_footer(1'b0);
      send_file(1'b1, file_q.size() - 2, 1'b1);
      put_header(GOOD_MAGIC, FILE_VERSION, 16'd0);
      put_record(0, 1'b1, 1, PAIR_GOOD);
      put_footer(1'b0);
      send_file(1'b1, file_q.size() - 1, 1'b1);

      // new file starts in the middle of another
      put_header(GOOD_MAGIC, FILE_VERSION, 16'hFFFF);
      put_record(0, 1'b1, 2, PAIR_GOOD);
      put_record(6, 1'b0, 1, PAIR_GOOD);
      send_file(1'b1, -1, 1'b0);
      put_header(GOOD_MAGIC, FILE_VERSION, 16'd0);
      put_record(0, 1'b1, 1, PAIR_FULL);
      put_footer(1'b0);
      send_file(1'b1, -1, 1'b1);

      // random files up to the overall request count
      while (items_sent < ITEM_TARGET) random_file();
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && results_owed == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* filelist.f */
design/blrc_pkg.sv
design/blrc_skid.sv
design/blrc_parser.sv
design/binary_link_record_checker_top.sv
tb/blrc_result_checker.sv
tb/tb_binary_link_record_checker_top.sv
